[sv/point_angle_arc_membership_macros.svh]
// ----------------------------------------------------------------------------
// Point angle arc membership - assertion macros
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef POINT_ANGLE_ARC_MEMBERSHIP_MACROS_SVH
`define POINT_ANGLE_ARC_MEMBERSHIP_MACROS_SVH

// Assert on every rising edge, reset included.
`define PAM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Assert on every rising edge outside reset.
`define PAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

[sv/pam_pkg.sv]
// ----------------------------------------------------------------------------
// Point angle arc membership - package
// Widths, codes, angle constants and the arctangent table.
// ----------------------------------------------------------------------------
package pam_pkg;

    localparam int MAX_SECTORS  = 8;
    localparam int CORDIC_STEPS = 20;

    localparam int COORD_W   = 24;
    localparam int ANG_W     = 25;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int TRUNC_W   = 16;
    localparam int FRAC_W    = 16;
    localparam int X_W       = 44;
    localparam int Z_W       = 25;
    localparam int TAB_W     = 22;
    localparam int SHAMT_W   = 5;
    localparam int STEP_W    = $clog2(CORDIC_STEPS);
    localparam int SEC_AW    = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int LIM_W     = (SEC_AW + 1 > CNT_W) ? SEC_AW + 1 : CNT_W;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 32;

    localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90 * 65536);
    localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(180 * 65536);
    localparam logic [ANG_W-1:0] ANG_270 = ANG_W'(270 * 65536);
    localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(360 * 65536);

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X     = 2'd0,
        CFG_CENTER_Y     = 2'd1,
        CFG_SECTOR_COUNT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CORDIC,
        ST_ANGLE,
        ST_SECTOR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic run;
    } t_cordic_ctl;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic [TAB_W-1:0] atan_lut(input logic [SHAMT_W-1:0] i);
        logic [TAB_W-1:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // whole units of a Q16.8 coordinate, truncated toward zero
    function automatic logic signed [TRUNC_W-1:0] trunc_units(
        input logic signed [COORD_W-1:0] v
    );
        logic signed [TRUNC_W-1:0] q;
        q = v[COORD_W-1:COORD_W-TRUNC_W];
        if (v[COORD_W-1] && (v[COORD_W-TRUNC_W-1:0] != '0)) begin
            q = q + TRUNC_W'(1);
        end
        return q;
    endfunction

endpackage

[sv/pam_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/pam_cordic.sv]
// ----------------------------------------------------------------------------
// CORDIC vectoring unit
// Shared shift-add step, one iteration per cycle while run is set, with its x, y, z registers.
// ----------------------------------------------------------------------------
module pam_cordic
    import pam_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cordic_ctl              i_ctl,
    input  logic [COORD_W-1:0]       i_x0,
    input  logic [COORD_W-1:0]       i_y0,
    output logic signed [Z_W-1:0]    o_z,
    output logic                     o_last
);

    logic signed [X_W-1:0]  r_x, r_y, n_x, n_y;
    logic signed [X_W-1:0]  w_xs, w_ys;
    logic signed [Z_W-1:0]  r_z, n_z, w_dz;
    logic [STEP_W-1:0]      r_step, n_step;
    logic [SHAMT_W-1:0]     w_shamt;

    assign w_shamt = SHAMT_W'(r_step);
    assign w_xs    = r_x >>> w_shamt;
    assign w_ys    = r_y >>> w_shamt;
    assign w_dz    = signed'(Z_W'(atan_lut(w_shamt)));

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_step = r_step;
        if (i_ctl.load) begin
            n_x    = signed'(X_W'({i_x0, {FRAC_W{1'b0}}}));
            n_y    = signed'(X_W'({i_y0, {FRAC_W{1'b0}}}));
            n_z    = '0;
            n_step = '0;
        end else if (i_ctl.run) begin
            // rotate toward the x axis, steered by the sign of y
            if (!r_y[X_W-1]) begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + w_dz;
            end else begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - w_dz;
            end
            n_step = STEP_W'(r_step + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_z    = r_z;
    assign o_last = (r_step == STEP_W'(CORDIC_STEPS - 1));

endmodule

[sv/pam_sector_cmp.sv]
// ----------------------------------------------------------------------------
// Sector compare unit
// Tests one angle against one removed sector, endpoint tolerance included.
// ----------------------------------------------------------------------------
module pam_sector_cmp
    import pam_pkg::*;
(
    input  logic [ANG_W-1:0] i_angle,
    input  logic [ANG_W-1:0] i_start,
    input  logic [ANG_W-1:0] i_end,
    output logic             o_inside
);

    localparam logic [ANG_W-1:0] MATCH_SCALE = ANG_W'(100000);
    localparam logic [ANG_W-1:0] MATCH_SPAN  = ANG_W'(256);

    // within one LSB or within 1e-5 of the larger value; the angle under test
    // never exceeds 360 degrees, so a relative match needs a distance below 256
    function automatic logic ends_match(input logic [ANG_W-1:0] a,
                                        input logic [ANG_W-1:0] b);
        logic [ANG_W-1:0] d;
        logic [ANG_W-1:0] m;
        logic [ANG_W-1:0] p;
        d = (a > b) ? a - b : b - a;
        m = (a > b) ? a : b;
        p = ANG_W'(d[7:0]) * MATCH_SCALE;
        return (d <= ANG_W'(1)) || ((d < MATCH_SPAN) && (p <= m));
    endfunction

    logic w_edge;
    logic w_within;

    assign w_edge = ends_match(i_angle, i_start) || ends_match(i_angle, i_end);

    always_comb begin
        if (i_start > i_end) begin
            w_within = ((i_angle > i_start) && (i_angle > i_end)) ||
                       ((i_angle < i_start) && (i_angle < i_end));
        end else begin
            w_within = (i_angle > i_start) && (i_angle < i_end);
        end
    end

    assign o_inside = !w_edge && w_within;

endmodule

[sv/point_angle_arc_membership.sv]
// ----------------------------------------------------------------------------
// Point angle arc membership
// Angle of a point about a center by CORDIC, tested against removed sectors.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid / tready        tuser: opcode; tdata: write or query fields
//  m_axis    out        tvalid / tready        tdata: angle, on_arc
//  cfg       in         wr_en (no wait)        wr_idx, wr_data
//
//  A query runs 20 CORDIC iterations on the one shift-add unit, then one
//  sector table read per active sector (the sector count, at most
//  MAX_SECTORS); the next transaction is accepted only once it is done.
//  An axis-snapped query skips the CORDIC loop.
//  Reset is synchronous; it clears the center, the sector count and control.
//  The sector table holds no reset value. A result stalled at m_axis waits in
//  the output register while the next transaction is taken and worked on.
// ----------------------------------------------------------------------------
module point_angle_arc_membership
    import pam_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: sector_index[2:0], new_start[27:3], new_end[52:28],
    //        point_x[76:53], point_y[100:77], zero pad
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: opcode[0]
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: angle[24:0], on_arc[25], zero pad
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_wr_idx,
    input  logic [CFG_W-1:0]       i_cfg_wr_data
);

    t_state                     r_state, n_state;
    logic signed [COORD_W-1:0]  r_cx, n_cx, r_cy, n_cy;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic signed [COORD_W-1:0]  r_px, n_px, r_py, n_py;
    logic [ANG_W-1:0]           r_angle, n_angle;
    logic [ANG_W-1:0]           r_off, n_off;
    logic                       r_on, n_on;
    logic [SEC_AW-1:0]          r_k, n_k;
    logic                       r_out_valid, n_out_valid;
    logic [ANG_W-1:0]           r_out_angle, n_out_angle;
    logic                       r_out_on, n_out_on;

    logic [IDX_W-1:0]           w_idx;
    logic [ANG_W-1:0]           w_new_start, w_new_end;
    logic signed [COORD_W-1:0]  w_in_px, w_in_py;
    logic                       w_in_acc, w_is_write;

    logic signed [COORD_W:0]    w_dx, w_dy, w_ndx, w_ndy;
    logic [COORD_W-1:0]         w_mag_dx, w_mag_dy;
    logic signed [TRUNC_W-1:0]  w_tcx, w_tcy, w_tpx, w_tpy;
    logic                       w_snap;
    logic [ANG_W-1:0]           w_snap_angle, w_quad_off, w_zc;
    logic [COORD_W-1:0]         w_x0, w_y0;

    logic [LIM_W-1:0]           w_n_eff;
    logic                       w_last_sec;

    t_cordic_ctl                w_cordic_ctl;
    logic signed [Z_W-1:0]      w_z;
    logic                       w_cordic_last;

    logic                       w_ram_we;
    logic [SEC_AW-1:0]          w_ram_waddr, w_ram_raddr;
    logic [2*ANG_W-1:0]         w_ram_rdata;
    logic                       w_inside;

    // input unpack
    assign w_idx       = i_s_axis_tdata[2:0];
    assign w_new_start = i_s_axis_tdata[27:3];
    assign w_new_end   = i_s_axis_tdata[52:28];
    assign w_in_px     = i_s_axis_tdata[76:53];
    assign w_in_py     = i_s_axis_tdata[100:77];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_write      = (t_opcode'(i_s_axis_tuser) == OP_WRITE);

    // sector table
    assign w_ram_we    = w_in_acc && w_is_write && (int'(w_idx) < MAX_SECTORS);
    assign w_ram_waddr = SEC_AW'(w_idx);
    assign w_ram_raddr = (r_state == ST_SECTOR) ? SEC_AW'(r_k + 1'b1) : '0;

    pam_ram #(
        .WIDTH (2 * ANG_W),
        .DEPTH (MAX_SECTORS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data ({w_new_end, w_new_start}),
        .i_rd_addr (w_ram_raddr),
        .o_rd_data (w_ram_rdata)
    );

    pam_sector_cmp u_cmp (
        .i_angle  (r_angle),
        .i_start  (w_ram_rdata[ANG_W-1:0]),
        .i_end    (w_ram_rdata[2*ANG_W-1:ANG_W]),
        .o_inside (w_inside)
    );

    // offsets and axis snapping
    assign w_dx     = {r_px[COORD_W-1], r_px} - {r_cx[COORD_W-1], r_cx};
    assign w_dy     = {r_py[COORD_W-1], r_py} - {r_cy[COORD_W-1], r_cy};
    assign w_ndx    = -w_dx;
    assign w_ndy    = -w_dy;
    assign w_mag_dx = w_dx[COORD_W] ? w_ndx[COORD_W-1:0] : w_dx[COORD_W-1:0];
    assign w_mag_dy = w_dy[COORD_W] ? w_ndy[COORD_W-1:0] : w_dy[COORD_W-1:0];

    assign w_tcx = trunc_units(r_cx);
    assign w_tcy = trunc_units(r_cy);
    assign w_tpx = trunc_units(r_px);
    assign w_tpy = trunc_units(r_py);

    always_comb begin
        w_snap       = 1'b1;
        w_snap_angle = ANG_90;
        if (w_tcy == w_tpy) begin
            w_snap_angle = (w_tcx > w_tpx) ? ANG_270 : ANG_90;
        end else if (w_tcx == w_tpx) begin
            w_snap_angle = (w_tcy < w_tpy) ? ANG_360 : ANG_180;
        end else begin
            w_snap = 1'b0;
        end
    end

    // quadrant picks the vector fed to the arctangent and its base angle
    always_comb begin
        if (!w_dx[COORD_W] && !w_dy[COORD_W]) begin
            w_quad_off = '0;
            w_x0       = w_mag_dy;
            w_y0       = w_mag_dx;
        end else if (!w_dx[COORD_W]) begin
            w_quad_off = ANG_90;
            w_x0       = w_mag_dx;
            w_y0       = w_mag_dy;
        end else if (w_dy[COORD_W]) begin
            w_quad_off = ANG_180;
            w_x0       = w_mag_dy;
            w_y0       = w_mag_dx;
        end else begin
            w_quad_off = ANG_270;
            w_x0       = w_mag_dx;
            w_y0       = w_mag_dy;
        end
    end

    assign w_cordic_ctl.load = (r_state == ST_SETUP) && !w_snap;
    assign w_cordic_ctl.run  = (r_state == ST_CORDIC);

    pam_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cordic_ctl),
        .i_x0    (w_x0),
        .i_y0    (w_y0),
        .o_z     (w_z),
        .o_last  (w_cordic_last)
    );

    // clamp the accumulated angle to [0, 90]
    always_comb begin
        if (w_z[Z_W-1]) begin
            w_zc = '0;
        end else if (w_z > signed'(Z_W'(ANG_90))) begin
            w_zc = ANG_90;
        end else begin
            w_zc = ANG_W'(w_z);
        end
    end

    assign w_n_eff    = (LIM_W'(r_cnt) > LIM_W'(MAX_SECTORS)) ? LIM_W'(MAX_SECTORS)
                                                              : LIM_W'(r_cnt);
    assign w_last_sec = ((LIM_W'(r_k) + LIM_W'(1)) == w_n_eff);

    always_comb begin
        n_state     = r_state;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cnt       = r_cnt;
        n_px        = r_px;
        n_py        = r_py;
        n_angle     = r_angle;
        n_off       = r_off;
        n_on        = r_on;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_angle = r_out_angle;
        n_out_on    = r_out_on;

        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_wr_idx))
                CFG_CENTER_X:     n_cx  = signed'(i_cfg_wr_data[COORD_W-1:0]);
                CFG_CENTER_Y:     n_cy  = signed'(i_cfg_wr_data[COORD_W-1:0]);
                CFG_SECTOR_COUNT: n_cnt = i_cfg_wr_data[CNT_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_px = w_in_px;
                    n_py = w_in_py;
                    if (w_is_write) begin
                        n_angle = '0;
                        n_on    = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                n_on = 1'b1;
                n_k  = '0;
                if (w_snap) begin
                    n_angle = w_snap_angle;
                    n_state = (w_n_eff == '0) ? ST_DONE : ST_SECTOR;
                end else begin
                    n_off   = w_quad_off;
                    n_state = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (w_cordic_last) begin
                    n_state = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                n_angle = r_off + w_zc;
                n_k     = '0;
                n_state = (w_n_eff == '0) ? ST_DONE : ST_SECTOR;
            end
            ST_SECTOR: begin
                // table data here belongs to entry r_k, read last cycle
                if (w_inside) begin
                    n_on = 1'b0;
                end
                if (w_last_sec) begin
                    n_state = ST_DONE;
                end else begin
                    n_k = SEC_AW'(r_k + 1'b1);
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_angle = r_angle;
                    n_out_on    = r_on;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cx        <= '0;
            r_cy        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_px        <= n_px;
        r_py        <= n_py;
        r_angle     <= n_angle;
        r_off       <= n_off;
        r_on        <= n_on;
        r_k         <= n_k;
        r_out_angle <= n_out_angle;
        r_out_on    <= n_out_on;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - ANG_W - 1){1'b0}}, r_out_on, r_out_angle};

endmodule

[sv/pam_checker.sv]
// ----------------------------------------------------------------------------
// Point angle arc membership - port checker
// Temporal checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_angle_arc_membership_macros.svh"

module pam_checker
    import pam_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    // no result may be pending right after reset
    `PAM_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

    // one transaction at a time: busy right after an accept
    `PAM_ASSERT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "input taken while busy")

    // a stalled result holds
    `PAM_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // angle stays within one turn
    `PAM_ASSERT(a_angle_range, o_m_axis_tvalid |-> o_m_axis_tdata[ANG_W-1:0] <= ANG_360, "angle above 360 degrees")

endmodule

bind point_angle_arc_membership pam_checker u_pam_checker (.*);
